// ----- src/gravity_accel_accumulator_defines.svh -----
// Assertion macros shared by the gravity accumulator RTL.
`ifndef GRAVITY_ACCEL_ACCUMULATOR_DEFINES_SVH
`define GRAVITY_ACCEL_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define GAA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define GAA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/gaa_pkg.sv -----
package gaa_pkg;

    localparam int FRAC_BITS = 16;
    // Numerator of the pull division is G*mass scaled by 2^(3*FRAC_BITS).
    localparam int NUM_W = 32 + 3 * FRAC_BITS;
    // The shift register also holds the 66-bit squared distance for the root.
    localparam int NQ_W = (NUM_W > 66) ? NUM_W : 66;
    localparam int CNT_W = $clog2(NQ_W + 1);

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_GRAV   = 2'd1;
    localparam logic [1:0] CFG_MAX    = 2'd2;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic [15:0]        source_mass;
        logic               has_source;
        logic               first_of_target;
        logic               last_of_target;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic               coincident_seen;
    } out_beat_t;

    // Clamp a 35-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- src/gaa_in_if.sv -----
interface gaa_in_if;
    logic              valid;
    logic              ready;
    gaa_pkg::in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/gaa_out_if.sv -----
interface gaa_out_if;
    logic               valid;
    logic               ready;
    gaa_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/gravity_accel_accumulator.sv -----
// Channel   Direction  Payload
// in        sink       target and source positions, source mass, item marks
// out       source     saturated acceleration and coincident flag
// cfg       write      gravity_enable, grav_const, max_accel by index
//
// An item without a source, or with gravity disabled, goes straight from S_IDLE to S_FIN.
// An item with a source at nonzero distance, from accept to the next accept, takes five passes
// through the shared 33x33 multiplier, a NUM_W-step division, a 33-step square root
// and two 64-step divisions, all on one shared compare-subtract unit, one bit a cycle.
// rst_n clears the sequencer, the running sums, the flag and the output valid.
// A finished result waits in the output register; the next beat is accepted
// while it waits, and only the next emission stalls until out.ready.
`include "gravity_accel_accumulator_defines.svh"

module gravity_accel_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    gaa_in_if.sink      in,
    gaa_out_if.source   out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_RSQ  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_GM   = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_MAG  = 4'd7;
    localparam logic [3:0] S_SQRT = 4'd8;
    localparam logic [3:0] S_MULX = 4'd9;
    localparam logic [3:0] S_LDX  = 4'd10;
    localparam logic [3:0] S_ACCX = 4'd11;
    localparam logic [3:0] S_LDY  = 4'd12;
    localparam logic [3:0] S_ACCY = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    localparam int NQ  = gaa_pkg::NQ_W;
    localparam int CW  = gaa_pkg::CNT_W;

    // Configuration registers.
    logic        enable_reg;
    logic [15:0] grav_reg;
    logic [30:0] max_reg;

    // Sequencer and item state.
    logic [3:0]          state_reg;
    logic [1:0]          phase_reg;
    logic [CW-1:0]       cnt_reg;
    logic                last_reg;
    logic signed [31:0]  tx_reg;
    logic signed [31:0]  ty_reg;
    logic [32:0]         ax_reg;
    logic [32:0]         ay_reg;
    logic                negx_reg;
    logic                negy_reg;
    logic [15:0]         mass_reg;

    // Datapath registers.
    logic [65:0]         prod_reg;
    logic [65:0]         rsq_reg;
    logic [30:0]         mag_reg;
    logic [32:0]         root_reg;
    logic [NQ-1:0]       nq_reg;
    logic [66:0]         rem_reg;

    // Running sums and output beat.
    logic signed [31:0]  sum_x_reg;
    logic signed [31:0]  sum_y_reg;
    logic                flag_reg;
    logic                out_valid_reg;
    gaa_pkg::out_beat_t  out_data_reg;

    // Shared multiplier operands.
    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic [65:0] mul_p;

    // Shared compare-subtract unit, used for every division and the root.
    logic [66:0] sub_a;
    logic [66:0] sub_b;
    logic [67:0] sub_d;
    logic        sub_ge;
    logic [66:0] rem_next;

    // Input side helpers.
    logic               in_fire;
    logic signed [32:0] dx_in;
    logic signed [32:0] dy_in;

    // Accumulation helpers.
    logic [63:0]        quo;
    logic [33:0]        quo_clip;
    logic signed [34:0] sum_ext;
    logic signed [34:0] acc_res;
    logic signed [31:0] acc_sat;
    logic               emit_ok;

    assign in.ready  = (state_reg == S_IDLE);
    assign in_fire   = in.valid && in.ready;
    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

    assign dx_in = {in.data.source_x[31], in.data.source_x}
                 - {in.data.target_x[31], in.data.target_x};
    assign dy_in = {in.data.source_y[31], in.data.source_y}
                 - {in.data.target_y[31], in.data.target_y};

    always_comb
    begin
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_CHK:
            begin
                mul_a = {17'd0, grav_reg};
                mul_b = {17'd0, mass_reg};
            end
            S_MULX:
            begin
                mul_a = ax_reg;
                mul_b = {2'd0, mag_reg};
            end
            S_ACCX:
            begin
                mul_a = ay_reg;
                mul_b = {2'd0, mag_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // A division shifts in one numerator bit; the root shifts in two radicand
    // bits and tries the root with a trailing 01.
    always_comb
    begin
        if (state_reg == S_SQRT) begin
            sub_a = {rem_reg[64:0], nq_reg[NQ-1 -: 2]};
            sub_b = {32'd0, root_reg, 2'b01};
        end else begin
            sub_a = {rem_reg[65:0], nq_reg[NQ-1]};
            sub_b = (phase_reg == 2'd0) ? {1'b0, rsq_reg} : {34'd0, root_reg};
        end
        sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_d[67];
        rem_next = sub_ge ? sub_d[66:0] : sub_a;
    end

    // A quotient of 2^33 or more saturates any 32-bit sum, so it is clipped.
    always_comb
    begin
        quo      = nq_reg[63:0];
        quo_clip = (|quo[63:33]) ? 34'h2_0000_0000 : {1'b0, quo[32:0]};
        if (state_reg == S_ACCX) begin
            sum_ext = 35'(sum_x_reg);
            acc_res = negx_reg ? (sum_ext - $signed({1'b0, quo_clip}))
                               : (sum_ext + $signed({1'b0, quo_clip}));
        end else begin
            sum_ext = 35'(sum_y_reg);
            acc_res = negy_reg ? (sum_ext - $signed({1'b0, quo_clip}))
                               : (sum_ext + $signed({1'b0, quo_clip}));
        end
        acc_sat = gaa_pkg::sat32(acc_res);
    end

    assign emit_ok = !out_valid_reg || out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg <= 1'b1;
            grav_reg   <= 16'd1000;
            max_reg    <= 31'd65536000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gaa_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                gaa_pkg::CFG_GRAV:   grav_reg   <= cfg_data[15:0];
                gaa_pkg::CFG_MAX:    max_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Control state and sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            phase_reg     <= 2'd0;
            cnt_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out.ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire) begin
                        if (in.data.first_of_target) begin
                            sum_x_reg <= '0;
                            sum_y_reg <= '0;
                            flag_reg  <= 1'b0;
                        end
                        state_reg <= (in.data.has_source && enable_reg) ? S_SQX : S_FIN;
                    end
                end
                S_SQX: state_reg <= S_SQY;
                S_SQY: state_reg <= S_RSQ;
                S_RSQ: state_reg <= S_CHK;
                S_CHK:
                begin
                    if (rsq_reg == '0) begin
                        flag_reg  <= 1'b1;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_GM;
                    end
                end
                S_GM:
                begin
                    phase_reg <= 2'd0;
                    cnt_reg   <= CW'(gaa_pkg::NUM_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        unique case (phase_reg)
                            2'd0:    state_reg <= S_MAG;
                            2'd1:    state_reg <= S_ACCX;
                            default: state_reg <= S_ACCY;
                        endcase
                    end
                end
                S_MAG:
                begin
                    cnt_reg   <= CW'(32);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_MULX;
                    end
                end
                S_MULX: state_reg <= S_LDX;
                S_LDX:
                begin
                    phase_reg <= 2'd1;
                    cnt_reg   <= CW'(63);
                    state_reg <= S_DIV;
                end
                S_ACCX:
                begin
                    sum_x_reg <= acc_sat;
                    state_reg <= S_LDY;
                end
                S_LDY:
                begin
                    phase_reg <= 2'd2;
                    cnt_reg   <= CW'(63);
                    state_reg <= S_DIV;
                end
                S_ACCY:
                begin
                    sum_y_reg <= acc_sat;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (emit_ok) begin
                        out_valid_reg <= 1'b1;
                        sum_x_reg     <= '0;
                        sum_y_reg     <= '0;
                        flag_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            tx_reg   <= in.data.target_x;
            ty_reg   <= in.data.target_y;
            mass_reg <= in.data.source_mass;
            last_reg <= in.data.last_of_target;
            negx_reg <= dx_in[32];
            negy_reg <= dy_in[32];
            ax_reg   <= dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
            ay_reg   <= dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
        end
        if (state_reg == S_SQX || state_reg == S_SQY || state_reg == S_CHK
            || state_reg == S_MULX || state_reg == S_ACCX) begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_SQY) begin
            rsq_reg <= prod_reg;
        end
        if (state_reg == S_RSQ) begin
            rsq_reg <= rsq_reg + prod_reg;
        end
        if (state_reg == S_GM) begin
            nq_reg  <= NQ'(prod_reg[31:0]) << (NQ - 32);
            rem_reg <= '0;
        end
        if (state_reg == S_DIV) begin
            nq_reg  <= {nq_reg[NQ-2:0], sub_ge};
            rem_reg <= rem_next;
        end
        if (state_reg == S_MAG) begin
            if ((|nq_reg[gaa_pkg::NUM_W-1:31]) || (nq_reg[30:0] > max_reg)) begin
                mag_reg <= max_reg;
            end else begin
                mag_reg <= nq_reg[30:0];
            end
            nq_reg   <= NQ'(rsq_reg) << (NQ - 66);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == S_SQRT) begin
            nq_reg   <= nq_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= {root_reg[31:0], sub_ge};
        end
        if (state_reg == S_LDX || state_reg == S_LDY) begin
            nq_reg  <= NQ'(prod_reg[63:0]) << (NQ - 64);
            rem_reg <= '0;
        end
        if (state_reg == S_FIN && last_reg && emit_ok) begin
            out_data_reg.accel_x <= gaa_pkg::sat32(35'(sum_x_reg) - 35'(tx_reg));
            out_data_reg.accel_y <= gaa_pkg::sat32(35'(sum_y_reg) - 35'(ty_reg));
            out_data_reg.coincident_seen <= flag_reg;
        end
    end

    `GAA_ASSERT_NEXT(a_src_starts, in_fire && in.data.has_source && enable_reg, state_reg == S_SQX, "source beat did not start the pull sequence")
    `GAA_ASSERT_NOW(a_div_nonzero, state_reg == S_DIV, (phase_reg == 2'd0) ? (rsq_reg != '0) : (root_reg != '0), "division by zero")
    `GAA_ASSERT_NOW(a_mag_clamped, state_reg == S_MULX, mag_reg <= max_reg, "pull magnitude above clamp")
    `GAA_ASSERT_NOW(a_emit_clears, $rose(out_valid_reg), sum_x_reg == '0 && sum_y_reg == '0 && !flag_reg, "sums not cleared on emission")

endmodule
